/* hw/rtl/mnu_pkg.sv */
package mnu_pkg;

    // Field widths
    localparam int ELEM_W = 32;
    localparam int MAG_W  = 32;
    localparam int NORM_W = 48;
    localparam int SQ_W   = 64;
    localparam int ROOT_W = 32;
    localparam int MODE_W = 2;
    localparam int ROWS_W = 16;
    localparam int COLS_W = 9;

    // Column store depth default
    localparam int MAX_COLS_DEF = 256;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_NORM_MODE = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT = 2'd1;
    localparam logic [1:0] REG_COL_COUNT = 2'd2;

    // Norm modes; mode bit 1 selects Frobenius
    localparam logic [MODE_W-1:0] MODE_COL_SUM = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROW_SUM = 2'd1;
    localparam int                MODE_FROB_BIT = 1;

    // Reset values of the registers
    localparam logic [ROWS_W-1:0] ROW_COUNT_RST = 16'd1;
    localparam logic [COLS_W-1:0] COL_COUNT_RST = 9'd1;

    // Saturation limit of row and column sums
    localparam logic [NORM_W-1:0] SUM_MAX = {NORM_W{1'b1}};

endpackage

/* hw/rtl/mnu_ifs.sv */
interface mnu_elem_if;
    import mnu_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface mnu_norm_if;
    import mnu_pkg::*;

    logic              valid;
    logic              ready;
    logic [NORM_W-1:0] norm_value;
    logic              saturated;

    modport source (output valid, output norm_value, output saturated, input ready);
    modport sink   (input valid, input norm_value, input saturated, output ready);
endinterface

/* hw/rtl/mnu_ram.sv */
module mnu_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/mnu_isqrt.sv */
module mnu_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mnu_pkg::SQ_W-1:0]   i_radicand,
    output logic                       o_done,
    output logic [mnu_pkg::ROOT_W-1:0] o_root
);
    import mnu_pkg::*;

    localparam int STEPS = SQ_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SQ_W-1:0]  r_rem;
    logic [SQ_W-1:0]  r_root;
    logic [SQ_W-1:0]  r_bit;
    logic [SQ_W-1:0]  trial;
    logic             take;

    // One digit per cycle: compare remainder with root plus bit
    assign trial = r_root + r_bit;
    assign take  = (r_rem >= trial);

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder, root and bit registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_radicand;
            r_root <= '0;
            r_bit  <= {2'b01, {(SQ_W-2){1'b0}}};
        end else if (r_busy) begin
            if (take) begin
                r_rem  <= r_rem - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[ROOT_W-1:0];
endmodule

/* hw/rtl/matrix_norm_unit_core.sv */
// Channel   Dir  Type           Payload                         Accepted when
// i_elem    in   mnu_elem_if    element_value (s32, Q16.16)     valid && ready
// o_norm    out  mnu_norm_if    norm_value (u48), saturated     valid && ready
// apb       in   psel/penable   norm_mode, row_count, col_count psel && penable && pwrite
//
// Each element passes through accept, multiply or column store read, and accumulate.
// After the last element of a matrix the output register is loaded; in Frobenius
// mode the square root comes first, one digit a cycle.
// Reset (synchronous, active low) returns registers to their reset values and clears positions and sums.
// A result waits in the output register while the next matrix streams in; only
// its load stalls until the sink takes the previous result.
module matrix_norm_unit_core #(
    parameter int MAX_COLS = mnu_pkg::MAX_COLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mnu_elem_if.sink                       i_elem,
    mnu_norm_if.source                     o_norm,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mnu_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mnu_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mnu_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import mnu_pkg::*;

    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [MODE_W-1:0] r_norm_mode;
    logic [ROWS_W-1:0] r_row_count;
    logic [COLS_W-1:0] r_col_count;
    logic [ROWS_W-1:0] r_row_pos;
    logic [COLS_W-1:0] r_col_pos;
    logic [MAG_W-1:0]  r_mag;
    logic [SQ_W-1:0]   r_prod;
    logic [NORM_W-1:0] r_row_sum;
    logic [NORM_W-1:0] r_best;
    logic [SQ_W-1:0]   r_sq_sum;
    logic              r_ovf;
    logic              r_out_valid;
    logic [NORM_W-1:0] r_out_norm;
    logic              r_out_sat;

    logic              cfg_wr;
    logic              cfg_clr;
    logic              elem_acc;
    logic              frob;
    logic              col_mode;
    logic [ROWS_W-1:0] nrows;
    logic [COLS_W-1:0] ncols_clamp;
    logic [COLS_W-1:0] ncols;
    logic              last_col;
    logic              last_row;
    logic [COLS_W+AW-1:0] col_ext;
    logic [AW-1:0]     col_addr;
    logic [NORM_W-1:0] ram_rdata;
    logic              ram_we;
    logic [SQ_W-1:0]   add_a;
    logic [SQ_W-1:0]   add_b;
    logic [SQ_W:0]     add_sum;
    logic              add_sat;
    logic [SQ_W-1:0]   acc_res;
    logic [NORM_W-1:0] acc48;
    logic              out_load;
    logic              sqrt_start;
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic [MAG_W-1:0]  mag_in;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Only a write to a defined register abandons the matrix in progress
    assign cfg_clr = cfg_wr && ((paddr[3:2] == REG_NORM_MODE) ||
                                (paddr[3:2] == REG_ROW_COUNT) ||
                                (paddr[3:2] == REG_COL_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_mode <= MODE_COL_SUM;
            r_row_count <= ROW_COUNT_RST;
            r_col_count <= COL_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_NORM_MODE: r_norm_mode <= pwdata[MODE_W-1:0];
                REG_ROW_COUNT: r_row_count <= pwdata[ROWS_W-1:0];
                REG_COL_COUNT: r_col_count <= pwdata[COLS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_NORM_MODE: prdata = APB_DATA_W'(r_norm_mode);
            REG_ROW_COUNT: prdata = APB_DATA_W'(r_row_count);
            REG_COL_COUNT: prdata = APB_DATA_W'(r_col_count);
            default:       prdata = '0;
        endcase
    end

    // Mode decode and matrix geometry
    assign frob        = r_norm_mode[MODE_FROB_BIT];
    assign col_mode    = (r_norm_mode == MODE_COL_SUM);
    assign nrows       = (r_row_count == '0) ? ROWS_W'(1) : r_row_count;
    assign ncols_clamp = (32'(r_col_count) > MAX_COLS) ? COLS_W'(MAX_COLS) : r_col_count;
    assign ncols       = (ncols_clamp == '0) ? COLS_W'(1) : ncols_clamp;
    assign last_col    = ({1'b0, r_col_pos} + 1'b1) >= {1'b0, ncols};
    assign last_row    = ({1'b0, r_row_pos} + 1'b1) >= {1'b0, nrows};
    assign col_ext     = {{AW{1'b0}}, r_col_pos};
    assign col_addr    = col_ext[AW-1:0];

    // Absolute value of the element
    assign elem_acc = i_elem.valid && i_elem.ready;
    assign mag_in   = i_elem.element_value[ELEM_W-1]
                    ? MAG_W'(-i_elem.element_value) : MAG_W'(i_elem.element_value);

    // Shared saturating adder
    always_comb begin
        if (frob) begin
            add_a = r_sq_sum;
            add_b = r_prod;
        end else if (col_mode) begin
            add_a = (r_row_pos == '0) ? '0 : SQ_W'(ram_rdata);
            add_b = SQ_W'(r_mag);
        end else begin
            add_a = SQ_W'(r_row_sum);
            add_b = SQ_W'(r_mag);
        end
        add_sum = {1'b0, add_a} + {1'b0, add_b};
        add_sat = frob ? add_sum[SQ_W] : (add_sum[SQ_W:NORM_W] != '0);
        if (add_sat) begin
            acc_res = frob ? {SQ_W{1'b1}} : SQ_W'(SUM_MAX);
        end else begin
            acc_res = add_sum[SQ_W-1:0];
        end
        acc48 = acc_res[NORM_W-1:0];
    end

    // Column accumulators
    assign ram_we = (r_state == S_ACC) && col_mode;

    mnu_ram #(
        .WIDTH (NORM_W),
        .DEPTH (MAX_COLS)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (col_addr),
        .i_wdata (acc48),
        .i_raddr (col_addr),
        .o_rdata (ram_rdata)
    );

    // Square root unit
    assign sqrt_start = (r_state == S_ACC) && frob && last_col && last_row;

    mnu_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (acc_res),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    // Sequencer
    assign out_load = (r_state == S_OUT) && (!r_out_valid || o_norm.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (elem_acc) n_state = S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC: begin
                if (last_col && last_row) begin
                    n_state = frob ? S_SQRT : S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SQRT: if (sqrt_done) n_state = S_OUT;
            S_OUT:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_elem.ready = (r_state == S_IDLE);

    // Latch magnitude and form the square
    always_ff @(posedge i_clk) begin
        if (elem_acc) begin
            r_mag <= mag_in;
        end
        if (r_state == S_MUL) begin
            r_prod <= SQ_W'(r_mag) * SQ_W'(r_mag);
        end
    end

    // Accumulate, advance positions, clear after a result or a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_clr || out_load) begin
            r_row_sum <= '0;
            r_best    <= '0;
            r_sq_sum  <= '0;
            r_ovf     <= 1'b0;
            if (!i_rst_n || cfg_clr) begin
                r_row_pos <= '0;
                r_col_pos <= '0;
            end
        end else if (r_state == S_ACC) begin
            if (add_sat) begin
                r_ovf <= 1'b1;
            end
            if (frob) begin
                r_sq_sum <= acc_res;
            end else if (col_mode) begin
                if (last_row && (acc48 > r_best)) begin
                    r_best <= acc48;
                end
            end else if (last_col) begin
                if (acc48 > r_best) begin
                    r_best <= acc48;
                end
                r_row_sum <= '0;
            end else begin
                r_row_sum <= acc48;
            end
            if (!last_col) begin
                r_col_pos <= r_col_pos + 1'b1;
            end else begin
                r_col_pos <= '0;
                r_row_pos <= last_row ? '0 : r_row_pos + 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_norm.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_norm <= frob ? NORM_W'(sqrt_root) : r_best;
            r_out_sat  <= r_ovf;
        end
    end

    assign o_norm.valid      = r_out_valid;
    assign o_norm.norm_value = r_out_norm;
    assign o_norm.saturated  = r_out_sat;
endmodule

/* hw/rtl/mnu_checker.sv */
module mnu_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [mnu_pkg::NORM_W-1:0] i_norm_value,
    input logic                       i_saturated,
    input logic                       i_pready
);
    import mnu_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_norm_value)
            && $stable(i_saturated))
        else $error("result changed while stalled");

    // The block works on one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item accepted while the previous one is at work");

    // A result needs at least the multiply and accumulate cycles
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared one cycle after an item");

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Configuration port never waits
    a_pready: assert property (@(posedge i_clk) i_pready)
        else $error("pready low");
endmodule

bind matrix_norm_unit_core mnu_checker u_mnu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_elem.valid),
    .i_in_ready   (i_elem.ready),
    .i_out_valid  (o_norm.valid),
    .i_out_ready  (o_norm.ready),
    .i_norm_value (o_norm.norm_value),
    .i_saturated  (o_norm.saturated),
    .i_pready     (pready)
);
